// ----- rtl/core/swsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Stopwatch split memory package
// Shared beat, time and control types for the stopwatch with split memory.
// ----------------------------------------------------------------------------
package swsm_pkg;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_VIEW       = 3'd1,
        CMD_START_STOP = 3'd2,
        CMD_SPLIT      = 3'd3,
        CMD_RST_PRESS  = 3'd4,
        CMD_RST_REL    = 3'd5,
        CMD_RST_TMO    = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } hms_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [4:0] read_index;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] disp_hours;
        logic [5:0] disp_minutes;
        logic [5:0] disp_seconds;
        logic       running;
        logic       chrono_view;
        logic [4:0] split_count;
        logic       split_full;
        logic       reset_pending;
        logic       split_valid;
        logic [6:0] split_hours;
        logic [5:0] split_minutes;
        logic [5:0] split_seconds;
    } out_beat_t;

    typedef struct packed {
        logic shift;
        logic append;
        hms_t data;
    } cell_ctrl_t;

    typedef struct packed {
        hms_t elapsed;
        logic running;
        logic chrono_view;
        logic hold;
    } ctrl_status_t;

endpackage

// ----- rtl/core/swsm_cell.sv -----
// ----------------------------------------------------------------------------
// Split cell
// One entry of the split row. It loads a new split when appended at its
// position, or takes its right neighbor's split when the row shifts.
// ----------------------------------------------------------------------------
module swsm_cell (
    input  logic                   clk,
    input  swsm_pkg::cell_ctrl_t   ctrl,
    input  logic                   load_sel,
    input  swsm_pkg::hms_t         shift_in,
    output swsm_pkg::hms_t         value,
    output swsm_pkg::hms_t         value_next
);

    swsm_pkg::hms_t value_reg;

    always_comb
    begin
        if (ctrl.shift)
        begin
            value_next = shift_in;
        end
        else if (ctrl.append && load_sel)
        begin
            value_next = ctrl.data;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/core/swsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Stopwatch control
// Holds the time count, view, run and reset-hold flags and the split count,
// and steers the split row for each accepted beat.
// ----------------------------------------------------------------------------
module swsm_ctrl #(
    parameter int SPLIT_DEPTH = 30,
    localparam int CntW = $clog2(SPLIT_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  swsm_pkg::cmd_t         cmd,
    input  logic                   cfg_write,
    input  logic                   cfg_data,
    output swsm_pkg::ctrl_status_t status,
    output swsm_pkg::cell_ctrl_t   cell_ctrl,
    output logic [CntW-1:0]        count,
    output logic [CntW-1:0]        count_next,
    output logic                   keep_latest
);

    logic           keep_latest_reg;
    logic           view_reg;
    logic           view_next;
    logic           run_reg;
    logic           run_next;
    logic           cleared_reg;
    logic           cleared_next;
    logic           hold_reg;
    logic           hold_next;
    swsm_pkg::hms_t elapsed_reg;
    swsm_pkg::hms_t elapsed_next;
    swsm_pkg::hms_t saved_reg;
    swsm_pkg::hms_t saved_next;
    logic [CntW-1:0] count_reg;
    logic           full;
    logic           reset_ok;

    function automatic swsm_pkg::hms_t advance_second(input swsm_pkg::hms_t t);
        swsm_pkg::hms_t r;
        r = t;
        if (t.seconds >= 6'd59)
        begin
            r.seconds = 6'd0;
            if (t.minutes >= 6'd59)
            begin
                r.minutes = 6'd0;
                r.hours   = (t.hours >= 7'd99) ? 7'd0 : t.hours + 7'd1;
            end
            else
            begin
                r.minutes = t.minutes + 6'd1;
            end
        end
        else
        begin
            r.seconds = t.seconds + 6'd1;
        end
        return r;
    endfunction

    assign full     = (count_reg == CntW'(SPLIT_DEPTH));
    assign reset_ok = view_reg && !run_reg && !cleared_reg;

    always_comb
    begin
        view_next        = view_reg;
        run_next         = run_reg;
        cleared_next     = cleared_reg;
        hold_next        = hold_reg;
        elapsed_next     = elapsed_reg;
        saved_next       = saved_reg;
        count_next       = count_reg;
        cell_ctrl.shift  = 1'b0;
        cell_ctrl.append = 1'b0;
        cell_ctrl.data   = elapsed_reg;
        if (accept)
        begin
            case (cmd)
                swsm_pkg::CMD_TICK:
                begin
                    if (run_reg)
                    begin
                        elapsed_next = advance_second(elapsed_reg);
                    end
                end
                swsm_pkg::CMD_VIEW:
                begin
                    view_next = !view_reg;
                end
                swsm_pkg::CMD_START_STOP:
                begin
                    if (view_reg)
                    begin
                        run_next = !run_reg;
                        if (run_reg)
                        begin
                            cleared_next = 1'b0;
                        end
                    end
                end
                swsm_pkg::CMD_SPLIT:
                begin
                    if (view_reg && run_reg)
                    begin
                        if (full)
                        begin
                            cell_ctrl.shift = keep_latest_reg;
                        end
                        else
                        begin
                            cell_ctrl.append = 1'b1;
                            count_next       = count_reg + CntW'(1);
                        end
                    end
                end
                swsm_pkg::CMD_RST_PRESS:
                begin
                    if (reset_ok)
                    begin
                        saved_next = elapsed_reg;
                        hold_next  = 1'b1;
                    end
                end
                swsm_pkg::CMD_RST_REL:
                begin
                    if (reset_ok)
                    begin
                        if (!hold_reg)
                        begin
                            elapsed_next = '0;
                            cleared_next = 1'b1;
                        end
                        else
                        begin
                            elapsed_next = saved_reg;
                        end
                        hold_next = 1'b0;
                    end
                end
                swsm_pkg::CMD_RST_TMO:
                begin
                    if (hold_reg)
                    begin
                        elapsed_next = '0;
                        hold_next    = 1'b0;
                        count_next   = '0;
                    end
                end
                swsm_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_latest_reg <= 1'b0;
            view_reg        <= 1'b0;
            run_reg         <= 1'b0;
            cleared_reg     <= 1'b1;
            hold_reg        <= 1'b0;
            elapsed_reg     <= '0;
            saved_reg       <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                keep_latest_reg <= cfg_data;
            end
            view_reg    <= view_next;
            run_reg     <= run_next;
            cleared_reg <= cleared_next;
            hold_reg    <= hold_next;
            elapsed_reg <= elapsed_next;
            saved_reg   <= saved_next;
            count_reg   <= count_next;
        end
    end

    assign status.elapsed     = elapsed_next;
    assign status.running     = run_next;
    assign status.chrono_view = view_next;
    assign status.hold        = hold_next;
    assign count              = count_reg;
    assign keep_latest        = keep_latest_reg;

endmodule

// ----- rtl/core/stopwatch_with_split_memory_top.sv -----
// ----------------------------------------------------------------------------
// Stopwatch with split memory
// Event-driven hh:mm:ss stopwatch with a row of split cells, oldest first.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while in_stall is low. Each
// accepted beat updates the control registers and the row of split cells,
// and its result is registered at the same edge, in the output register when
// that is free, else in the skid entry. A two-entry output stage lets the
// input keep flowing for one more beat while the output is stalled; input
// stall rises only when both entries hold results. When the split row is full
// and keep-latest is set, a new split shifts every cell one place toward the
// oldest end and enters at the newest end.
module stopwatch_with_split_memory_top #(
    parameter int SPLIT_DEPTH = 30
) (
    input  logic                cfg_write,
    input  logic                cfg_data,
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  swsm_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output swsm_pkg::out_beat_t out_beat
);

    localparam int CntW = $clog2(SPLIT_DEPTH + 1);
    localparam int CmpW = (CntW > 5) ? CntW : 5;
    localparam int HmsW = $bits(swsm_pkg::hms_t);

    logic                   in_acc;
    logic                   out_acc;
    swsm_pkg::ctrl_status_t status;
    swsm_pkg::cell_ctrl_t   cell_ctrl;
    logic [CntW-1:0]        count;
    logic [CntW-1:0]        count_next;
    logic [CmpW-1:0]        count_ext;
    logic                   keep_latest;
    swsm_pkg::hms_t         cell_value [SPLIT_DEPTH];
    swsm_pkg::hms_t         cell_next  [SPLIT_DEPTH];
    logic [HmsW-1:0]        split_pick;
    swsm_pkg::hms_t         split_time;
    logic                   split_valid;
    swsm_pkg::out_beat_t    result;
    logic                   out_valid_reg;
    swsm_pkg::out_beat_t    out_beat_reg;
    logic                   skid_valid_reg;
    swsm_pkg::out_beat_t    skid_beat_reg;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;

    swsm_ctrl #(
        .SPLIT_DEPTH(SPLIT_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_acc),
        .cmd         (in_beat.cmd),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .status      (status),
        .cell_ctrl   (cell_ctrl),
        .count       (count),
        .count_next  (count_next),
        .keep_latest (keep_latest)
    );

    genvar gi;
    generate
        for (gi = 0; gi < SPLIT_DEPTH; gi++)
        begin : g_cell
            swsm_pkg::hms_t shift_in;
            if (gi == SPLIT_DEPTH - 1)
            begin : g_last
                assign shift_in = cell_ctrl.data;
            end
            else
            begin : g_mid
                assign shift_in = cell_value[gi+1];
            end
            swsm_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .load_sel   (count == CntW'(gi)),
                .shift_in   (shift_in),
                .value      (cell_value[gi]),
                .value_next (cell_next[gi])
            );
        end
    endgenerate

    assign count_ext   = CmpW'(count_next);
    assign split_valid = (CmpW'(in_beat.read_index) < count_ext);

    always_comb
    begin
        split_pick = '0;
        for (int i = 0; i < SPLIT_DEPTH; i++)
        begin
            if (CmpW'(in_beat.read_index) == CmpW'(i))
            begin
                split_pick = split_pick | cell_next[i];
            end
        end
    end

    assign split_time = split_valid ? swsm_pkg::hms_t'(split_pick) : '0;

    always_comb
    begin
        result.disp_hours    = status.elapsed.hours;
        result.disp_minutes  = status.elapsed.minutes;
        result.disp_seconds  = status.elapsed.seconds;
        result.running       = status.running;
        result.chrono_view   = status.chrono_view;
        result.split_count   = count_ext[4:0];
        result.split_full    = (count_next == CntW'(SPLIT_DEPTH)) && !keep_latest;
        result.reset_pending = status.hold;
        result.split_valid   = split_valid;
        result.split_hours   = split_time.hours;
        result.split_minutes = split_time.minutes;
        result.split_seconds = split_time.seconds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_acc || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_acc;
                end
            end
            else if (in_acc)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_acc || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_beat_reg <= skid_beat_reg;
            end
            else if (in_acc)
            begin
                out_beat_reg <= result;
            end
        end
        else if (in_acc)
        begin
            skid_beat_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry is valid while the output register is empty.");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("Accepted beat did not produce a result.");

    a_shift_append_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cell_ctrl.shift && cell_ctrl.append))
        else $error("Split row shifted and appended in the same cycle.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CntW'(SPLIT_DEPTH))
        else $error("Split count exceeds the row depth.");

    a_shift_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.shift |-> (count == CntW'(SPLIT_DEPTH)) && keep_latest)
        else $error("Split row shifted while not full or in keep-oldest mode.");
`endif

endmodule
